FILE: rtl/lup_pkg.sv
// ----------------------------------------------------------------------------
// lup_pkg: shared definitions for the length-to-pixels converter
// Unit codes, divider select codes, scale factors, reciprocal constants for
// the constant divisions, and the structs passed between pipeline modules.
// ----------------------------------------------------------------------------
package lup_pkg;

  // Unit codes of the input item. Codes above UNIT_VH count as px.
  localparam logic [3:0] UNIT_PX  = 4'd0;
  localparam logic [3:0] UNIT_EM  = 4'd1;
  localparam logic [3:0] UNIT_REM = 4'd2;
  localparam logic [3:0] UNIT_EX  = 4'd3;
  localparam logic [3:0] UNIT_CH  = 4'd4;
  localparam logic [3:0] UNIT_PT  = 4'd5;
  localparam logic [3:0] UNIT_PC  = 4'd6;
  localparam logic [3:0] UNIT_IN  = 4'd7;
  localparam logic [3:0] UNIT_CM  = 4'd8;
  localparam logic [3:0] UNIT_MM  = 4'd9;
  localparam logic [3:0] UNIT_VW  = 4'd10;
  localparam logic [3:0] UNIT_VH  = 4'd11;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
  localparam logic [15:0] VP_WIDTH_RST  = 16'd1024;
  localparam logic [15:0] VP_HEIGHT_RST = 16'd768;

  // Divisor applied to the magnitude before scaling.
  localparam logic [1:0] DIV_NONE = 2'd0;
  localparam logic [1:0] DIV_3    = 2'd1;
  localparam logic [1:0] DIV_127  = 2'd2;
  localparam logic [1:0] DIV_VP   = 2'd3;

  localparam logic [31:0] DVS_3   = 32'd3;
  localparam logic [31:0] DVS_127 = 32'd127;
  localparam logic [31:0] DVS_VP  = 32'd100000;

  // Scale factors. cm and mm use 9600/254 = 4800/127 and 960/254 = 480/127.
  localparam logic [15:0] K_ONE = 16'd1;
  localparam logic [15:0] K_PT  = 16'd4;
  localparam logic [15:0] K_PC  = 16'd16;
  localparam logic [15:0] K_IN  = 16'd96;
  localparam logic [15:0] K_CM  = 16'd4800;
  localparam logic [15:0] K_MM  = 16'd480;

  // Reciprocals: q = (x * ceil(2^s / d)) >> s is exact for x below 2^N
  // when 2^(s-N) >= d.
  // Quotient of the 32-bit magnitude.
  localparam int Q_SH_3   = 34;
  localparam int Q_SH_127 = 39;
  localparam int Q_SH_VP  = 49;
  localparam logic [63:0] Q_MG_3   = ((64'd1 << Q_SH_3) + 64'd2) / 64'd3;
  localparam logic [63:0] Q_MG_127 = ((64'd1 << Q_SH_127) + 64'd126) / 64'd127;
  localparam logic [63:0] Q_MG_VP  = ((64'd1 << Q_SH_VP) + 64'd99999) / 64'd100000;

  // Quotient of the scaled remainder. For viewport units the remainder
  // product is first shifted by five, so the divisor is 3125.
  localparam int Y_SH_3   = 6;
  localparam int Y_SH_127 = 27;
  localparam int Y_SH_VP  = 40;
  localparam logic [63:0] Y_MG_3   = ((64'd1 << Y_SH_3) + 64'd2) / 64'd3;
  localparam logic [63:0] Y_MG_127 = ((64'd1 << Y_SH_127) + 64'd126) / 64'd127;
  localparam logic [63:0] Y_MG_VP  = ((64'd1 << Y_SH_VP) + 64'd3124) / 64'd3125;

  // Rounding from thousandths: (t >> 3) / 125.
  localparam int R_SH = 34;
  localparam logic [63:0] R_MG = ((64'd1 << R_SH) + 64'd124) / 64'd125;

  localparam logic [30:0] RND_HALF = 31'd500;
  localparam logic [30:0] RND_SAT  = 31'd1000000500;
  localparam logic [30:0] VP_SAT   = 31'd1000000;
  localparam logic [19:0] PX_LIMIT = 20'd1000000;

  // Pipeline depth of valid tracking: input, A, B, C, D, E stages.
  localparam int unsigned NSTG = 6;

  typedef struct packed {
    logic s0;
    logic sa;
    logic sb;
    logic sc;
    logic sd;
    logic se;
    logic so;
  } lup_en_t;

  typedef struct packed {
    logic [16:0] r;
    logic [29:0] kq;
    logic        ovf;
    logic [15:0] k;
    logic [1:0]  sel;
    logic        rnd;
    logic        neg;
  } lup_mid_t;

endpackage

FILE: rtl/lup_front.sv
// ----------------------------------------------------------------------------
// lup_front: input register, quotient stage and remainder/scale stage
// Splits the magnitude as q * d + r for the unit's divisor d and scales the
// quotient by the unit's factor.
// ----------------------------------------------------------------------------
module lup_front (
  input  logic               clk,
  input  lup_pkg::lup_en_t   en,
  input  logic signed [31:0] amount_milli,
  input  logic [3:0]         unit_code,
  input  logic [8:0]         font_px,
  input  logic [8:0]         root_font_px,
  input  logic [15:0]        vp_width,
  input  logic [15:0]        vp_height,
  output lup_pkg::lup_mid_t  mid
);

  logic [31:0] amt_r;
  logic [3:0]  unit_r;
  logic [8:0]  fs_r;
  logic [8:0]  rfs_r;

  logic [31:0] a_mag_r, a_mag_nxt;
  logic [31:0] a_q_r, a_q_nxt;
  logic [15:0] a_k_r, a_k_nxt;
  logic [1:0]  a_sel_r, a_sel_nxt;
  logic        a_rnd_r, a_rnd_nxt;
  logic        a_neg_r, a_neg_nxt;

  logic [7:0]  half_fs;
  logic [32:0] q_magic;
  logic [64:0] q_prod;

  logic [31:0]       qd;
  logic [31:0]       rem_full;
  logic [47:0]       kq;
  lup_pkg::lup_mid_t mid_r, mid_nxt;

  always_ff @(posedge clk) begin
    if (en.s0) begin
      amt_r  <= amount_milli;
      unit_r <= unit_code;
      fs_r   <= font_px;
      rfs_r  <= root_font_px;
    end
  end

  // Stage A: magnitude, unit decode and quotient by reciprocal.
  always_comb begin
    a_neg_nxt = amt_r[31];
    a_mag_nxt = amt_r[31] ? (~amt_r + 32'd1) : amt_r;
    half_fs   = (fs_r[8:1] == 8'd0) ? 8'd1 : fs_r[8:1];
    a_sel_nxt = lup_pkg::DIV_NONE;
    a_rnd_nxt = 1'b1;
    case (unit_r) inside
      lup_pkg::UNIT_EM:                  a_k_nxt = 16'(fs_r);
      lup_pkg::UNIT_REM:                 a_k_nxt = 16'(rfs_r);
      lup_pkg::UNIT_EX, lup_pkg::UNIT_CH: a_k_nxt = 16'(half_fs);
      lup_pkg::UNIT_PT: begin
        a_k_nxt   = lup_pkg::K_PT;
        a_sel_nxt = lup_pkg::DIV_3;
      end
      lup_pkg::UNIT_PC:                  a_k_nxt = lup_pkg::K_PC;
      lup_pkg::UNIT_IN:                  a_k_nxt = lup_pkg::K_IN;
      lup_pkg::UNIT_CM: begin
        a_k_nxt   = lup_pkg::K_CM;
        a_sel_nxt = lup_pkg::DIV_127;
      end
      lup_pkg::UNIT_MM: begin
        a_k_nxt   = lup_pkg::K_MM;
        a_sel_nxt = lup_pkg::DIV_127;
      end
      lup_pkg::UNIT_VW: begin
        a_k_nxt   = vp_width;
        a_sel_nxt = lup_pkg::DIV_VP;
        a_rnd_nxt = 1'b0;
      end
      lup_pkg::UNIT_VH: begin
        a_k_nxt   = vp_height;
        a_sel_nxt = lup_pkg::DIV_VP;
        a_rnd_nxt = 1'b0;
      end
      default:                           a_k_nxt = lup_pkg::K_ONE;
    endcase

    case (a_sel_nxt)
      lup_pkg::DIV_3:   q_magic = lup_pkg::Q_MG_3[32:0];
      lup_pkg::DIV_127: q_magic = lup_pkg::Q_MG_127[32:0];
      lup_pkg::DIV_VP:  q_magic = lup_pkg::Q_MG_VP[32:0];
      default:          q_magic = 33'd0;
    endcase
    q_prod = 65'(a_mag_nxt) * 65'(q_magic);

    case (a_sel_nxt)
      lup_pkg::DIV_3:   a_q_nxt = 32'(q_prod >> lup_pkg::Q_SH_3);
      lup_pkg::DIV_127: a_q_nxt = 32'(q_prod >> lup_pkg::Q_SH_127);
      lup_pkg::DIV_VP:  a_q_nxt = 32'(q_prod >> lup_pkg::Q_SH_VP);
      default:          a_q_nxt = a_mag_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.sa) begin
      a_mag_r <= a_mag_nxt;
      a_q_r   <= a_q_nxt;
      a_k_r   <= a_k_nxt;
      a_sel_r <= a_sel_nxt;
      a_rnd_r <= a_rnd_nxt;
      a_neg_r <= a_neg_nxt;
    end
  end

  // Stage B: remainder and scaled quotient. Anything at or above 2^30 in
  // the scaled quotient saturates every unit.
  always_comb begin
    case (a_sel_r)
      lup_pkg::DIV_3:   qd = a_q_r * lup_pkg::DVS_3;
      lup_pkg::DIV_127: qd = a_q_r * lup_pkg::DVS_127;
      lup_pkg::DIV_VP:  qd = a_q_r * lup_pkg::DVS_VP;
      default:          qd = a_mag_r;
    endcase
    rem_full    = a_mag_r - qd;
    kq          = 48'(a_k_r) * 48'(a_q_r);
    mid_nxt.r   = rem_full[16:0];
    mid_nxt.kq  = kq[29:0];
    mid_nxt.ovf = |kq[47:30];
    mid_nxt.k   = a_k_r;
    mid_nxt.sel = a_sel_r;
    mid_nxt.rnd = a_rnd_r;
    mid_nxt.neg = a_neg_r;
  end

  always_ff @(posedge clk) begin
    if (en.sb) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

FILE: rtl/lup_back.sv
// ----------------------------------------------------------------------------
// lup_back: remainder scaling, combine, rounding and saturation stages
// Adds the scaled remainder quotient to the scaled quotient, rounds from
// thousandths where the unit calls for it and applies sign and limits.
// ----------------------------------------------------------------------------
module lup_back (
  input  logic               clk,
  input  lup_pkg::lup_en_t   en,
  input  lup_pkg::lup_mid_t  mid,
  output logic signed [20:0] pixels
);

  logic [32:0] c_y_r, c_y_nxt;
  logic [29:0] c_kq_r;
  logic        c_ovf_r;
  logic [1:0]  c_sel_r;
  logic        c_rnd_r;
  logic        c_neg_r;

  logic [27:0] y_num;
  logic [28:0] y_magic;
  logic [56:0] y_prod;
  logic [15:0] d_ydiv_r, d_ydiv_nxt;
  logic [29:0] d_kq_r;
  logic        d_ovf_r;
  logic        d_rnd_r;
  logic        d_neg_r;

  logic [30:0] sum;
  logic [30:0] e_val_r, e_val_nxt;
  logic        e_sat_r, e_sat_nxt;
  logic        e_rnd_r;
  logic        e_neg_r;

  logic [54:0]        r_prod;
  logic [19:0]        res_mag;
  logic signed [20:0] pix_r, pix_nxt;

  // Stage C: scale the remainder.
  assign c_y_nxt = 33'(mid.k) * 33'(mid.r);

  always_ff @(posedge clk) begin
    if (en.sc) begin
      c_y_r   <= c_y_nxt;
      c_kq_r  <= mid.kq;
      c_ovf_r <= mid.ovf;
      c_sel_r <= mid.sel;
      c_rnd_r <= mid.rnd;
      c_neg_r <= mid.neg;
    end
  end

  // Stage D: divide the scaled remainder by the same divisor.
  always_comb begin
    case (c_sel_r)
      lup_pkg::DIV_3: begin
        y_num   = 28'(c_y_r[3:0]);
        y_magic = lup_pkg::Y_MG_3[28:0];
      end
      lup_pkg::DIV_127: begin
        y_num   = 28'(c_y_r[19:0]);
        y_magic = lup_pkg::Y_MG_127[28:0];
      end
      lup_pkg::DIV_VP: begin
        y_num   = c_y_r[32:5];
        y_magic = lup_pkg::Y_MG_VP[28:0];
      end
      default: begin
        y_num   = 28'd0;
        y_magic = 29'd0;
      end
    endcase
    y_prod = 57'(y_num) * 57'(y_magic);
    case (c_sel_r)
      lup_pkg::DIV_3:   d_ydiv_nxt = 16'(y_prod >> lup_pkg::Y_SH_3);
      lup_pkg::DIV_127: d_ydiv_nxt = 16'(y_prod >> lup_pkg::Y_SH_127);
      lup_pkg::DIV_VP:  d_ydiv_nxt = 16'(y_prod >> lup_pkg::Y_SH_VP);
      default:          d_ydiv_nxt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.sd) begin
      d_ydiv_r <= d_ydiv_nxt;
      d_kq_r   <= c_kq_r;
      d_ovf_r  <= c_ovf_r;
      d_rnd_r  <= c_rnd_r;
      d_neg_r  <= c_neg_r;
    end
  end

  // Stage E: combine, add the rounding half when rounding, find saturation.
  always_comb begin
    sum = 31'(d_kq_r) + 31'(d_ydiv_r);
    if (d_rnd_r) begin
      e_val_nxt = sum + lup_pkg::RND_HALF;
      e_sat_nxt = d_ovf_r || (sum >= lup_pkg::RND_SAT);
    end else begin
      e_val_nxt = sum;
      e_sat_nxt = d_ovf_r || (sum > lup_pkg::VP_SAT);
    end
  end

  always_ff @(posedge clk) begin
    if (en.se) begin
      e_val_r <= e_val_nxt;
      e_sat_r <= e_sat_nxt;
      e_rnd_r <= d_rnd_r;
      e_neg_r <= d_neg_r;
    end
  end

  // Output stage: rounded units divide by 1000 via >> 3 and reciprocal of 125.
  always_comb begin
    r_prod = 55'(e_val_r[29:3]) * 55'(lup_pkg::R_MG[27:0]);
    if (e_sat_r) begin
      res_mag = lup_pkg::PX_LIMIT;
    end else if (e_rnd_r) begin
      res_mag = 20'(r_prod >> lup_pkg::R_SH);
    end else begin
      res_mag = e_val_r[19:0];
    end
    pix_nxt = e_neg_r ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
  end

  always_ff @(posedge clk) begin
    if (en.so) begin
      pix_r <= pix_nxt;
    end
  end

  assign pixels = pix_r;

endmodule

FILE: rtl/length_unit_to_pixels.sv
// ----------------------------------------------------------------------------
// length_unit_to_pixels: converts a length in thousandths of a unit to pixels
// Seven-stage pipeline with per-stage valid bits and viewport registers.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  in_     | input     | in_valid / in_ready    | amount_milli, unit_code,
//          |           |                        | font_px, root_font_px
//  out_    | output    | out_valid / out_ready  | pixels
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transfer is accepted per cycle while in_ready is high; each result
// passes through the input, A to E and output registers in order.
// Every stage holds its item until the next one is free, so bubbles close
// up and input is stalled only when all stages and the output are full.
// Reset is synchronous, clears the valid bits and sets the viewport registers
// to 1024 by 768. cfg_ready is always high.
// ----------------------------------------------------------------------------
module length_unit_to_pixels (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_amount_milli,
  input  logic [3:0]                      in_unit_code,
  input  logic [8:0]                      in_font_px,
  input  logic [8:0]                      in_root_font_px,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [20:0]              out_pixels,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lup_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);

  logic [15:0] vp_width_r;
  logic [15:0] vp_height_r;

  logic [lup_pkg::NSTG-1:0] vld_r, vld_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [lup_pkg::NSTG:0]   ld;
  lup_pkg::lup_en_t         en;
  lup_pkg::lup_mid_t        mid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_width_r  <= lup_pkg::VP_WIDTH_RST;
      vp_height_r <= lup_pkg::VP_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lup_pkg::REG_VP_WIDTH:  vp_width_r  <= cfg_data;
        lup_pkg::REG_VP_HEIGHT: vp_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its item moves on this cycle.
  always_comb begin
    ld[lup_pkg::NSTG] = !out_valid_r || out_ready;
    for (int s = lup_pkg::NSTG - 1; s >= 0; s--) begin
      ld[s] = !vld_r[s] || ld[s+1];
    end
    vld_nxt[0] = ld[0] ? in_valid : vld_r[0];
    for (int s = 1; s < lup_pkg::NSTG; s++) begin
      vld_nxt[s] = ld[s] ? vld_r[s-1] : vld_r[s];
    end
    out_valid_nxt = ld[lup_pkg::NSTG] ? vld_r[lup_pkg::NSTG-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign en.s0 = ld[0];
  assign en.sa = ld[1];
  assign en.sb = ld[2];
  assign en.sc = ld[3];
  assign en.sd = ld[4];
  assign en.se = ld[5];
  assign en.so = ld[6];

  assign in_ready  = ld[0];
  assign out_valid = out_valid_r;

  lup_front u_front (
    .clk          (clk),
    .en           (en),
    .amount_milli (in_amount_milli),
    .unit_code    (in_unit_code),
    .font_px      (in_font_px),
    .root_font_px (in_root_font_px),
    .vp_width     (vp_width_r),
    .vp_height    (vp_height_r),
    .mid          (mid)
  );

  lup_back u_back (
    .clk    (clk),
    .en     (en),
    .mid    (mid),
    .pixels (out_pixels)
  );

`ifndef ASSERT_OFF
  // Results never leave the saturation range.
  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixels <= 21'sd1000000 && out_pixels >= -21'sd1000000))
    else $error("pixels outside the saturation range");

  // Input stalls only when the whole pipeline is full and the output waits.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && vld_r[0] && vld_r[lup_pkg::NSTG-1]))
    else $error("input stalled with room in the pipeline");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");
`endif

endmodule
